/* rtl/jmsp_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment parser package
// Shared types, marker codes and event record for the parser front end,
// the event queue and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package jmsp_pkg;

  // Luma blocks per MCU until an SOF0 segment says otherwise
  localparam logic [2:0] DEFAULT_LUMA_BLOCKS = 3'd2;

  // Marker and byte codes
  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_00    = 8'h00;
  localparam logic [7:0] MK_SOI     = 8'hD8;
  localparam logic [7:0] MK_EOI     = 8'hD9;
  localparam logic [7:0] MK_SOF0    = 8'hC0;
  localparam logic [7:0] MK_DQT     = 8'hDB;
  localparam logic [7:0] MK_SOS     = 8'hDA;
  localparam logic [7:0] MK_RST0    = 8'hD0;
  localparam logic [7:0] MK_RST7    = 8'hD7;
  localparam logic [7:0] SAMP_H2V2  = 8'h22;
  localparam logic [7:0] SAMP_H2V1  = 8'h21;
  localparam logic [2:0] LUMA_H2V2  = 3'd4;
  localparam logic [2:0] LUMA_H2V1  = 3'd2;

  // Segment length handling
  localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

  // DQT body: a table-id byte opens every row of 65 bytes
  localparam int unsigned DQT_ROW_LEN = 65;
  localparam int unsigned DQT_CNT_W   = $clog2(DQT_ROW_LEN);
  localparam logic [DQT_CNT_W-1:0] DQT_ROW_LAST = DQT_CNT_W'(DQT_ROW_LEN - 1);

  // SOF0 body positions
  localparam logic [15:0] SOF_HEIGHT_HI = 16'd1;
  localparam logic [15:0] SOF_HEIGHT_LO = 16'd2;
  localparam logic [15:0] SOF_WIDTH_HI  = 16'd3;
  localparam logic [15:0] SOF_WIDTH_LO  = 16'd4;
  localparam logic [15:0] SOF_SAMPLING  = 16'd7;

  // Event queue depth
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_SEARCH  = 4'd0,
    ST_SOI     = 4'd1,
    ST_FRAME   = 4'd2,
    ST_MARK    = 4'd3,
    ST_LEN1    = 4'd4,
    ST_LEN2    = 4'd5,
    ST_BODY    = 4'd6,
    ST_SCAN    = 4'd7,
    ST_SCAN_FF = 4'd8
  } parse_state_e;

  typedef enum logic [2:0] {
    EV_MARKER     = 3'd0,
    EV_SCAN_BYTE  = 3'd1,
    EV_SCAN_START = 3'd2,
    EV_RESTART    = 3'd3,
    EV_QUANT      = 3'd4
  } ev_kind_e;

  // Compact event record: one data byte whose meaning follows the kind
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  data;
    logic        quant_table;
    logic [5:0]  quant_index;
    logic [15:0] height;
    logic [15:0] width;
    logic [2:0]  luma;
  } event_t;

endpackage

`default_nettype wire

/* rtl/jmsp_front.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment parser front end
// Accepts one byte per cycle while accept_i is high, walks the marker segments
// and emits a compact event record for each byte that causes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  output jmsp_pkg::event_t      event_o,
  output logic                  event_valid_o
);

  jmsp_pkg::parse_state_e state_q, state_d;
  logic [7:0]  marker_q, marker_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [jmsp_pkg::DQT_CNT_W-1:0] row_q, row_d;
  logic [7:0]  tid_q, tid_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;
  logic [2:0]  luma_q, luma_d;

  logic                 ev_valid;
  jmsp_pkg::ev_kind_e   ev_kind;
  logic [7:0]           ev_data;
  logic                 ev_qt;
  logic [5:0]           ev_qi;
  logic                 end_seg;
  logic [15:0]          full_len;
  logic [15:0]          pos_inc;
  logic [jmsp_pkg::DQT_CNT_W-1:0] row_idx;

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= jmsp_pkg::ST_SEARCH;
      marker_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      row_q    <= '0;
      tid_q    <= '0;
      height_q <= '0;
      width_q  <= '0;
      luma_q   <= jmsp_pkg::DEFAULT_LUMA_BLOCKS;
    end else begin
      state_q  <= state_d;
      marker_q <= marker_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      row_q    <= row_d;
      tid_q    <= tid_d;
      height_q <= height_d;
      width_q  <= width_d;
      luma_q   <= luma_d;
    end
  end

  assign full_len = {len_q[15:8], data_byte_i};
  assign pos_inc  = pos_q + 16'd1;
  assign row_idx  = row_q - jmsp_pkg::DQT_CNT_W'(1);

  // Next state and event decode
  always_comb begin
    state_d  = state_q;
    marker_d = marker_q;
    len_d    = len_q;
    pos_d    = pos_q;
    row_d    = row_q;
    tid_d    = tid_q;
    height_d = height_q;
    width_d  = width_q;
    luma_d   = luma_q;
    ev_valid = 1'b0;
    ev_kind  = jmsp_pkg::EV_MARKER;
    ev_data  = '0;
    ev_qt    = 1'b0;
    ev_qi    = '0;
    end_seg  = 1'b0;

    if (accept_i) begin
      case (state_q)
        jmsp_pkg::ST_SOI: begin
          if (data_byte_i == jmsp_pkg::MK_SOI) begin
            ev_valid = 1'b1;
            ev_data  = data_byte_i;
            state_d  = jmsp_pkg::ST_FRAME;
          end else begin
            state_d = jmsp_pkg::ST_SEARCH;
          end
        end
        jmsp_pkg::ST_FRAME: begin
          state_d = (data_byte_i == jmsp_pkg::BYTE_FF) ? jmsp_pkg::ST_MARK
                                                        : jmsp_pkg::ST_SEARCH;
        end
        jmsp_pkg::ST_MARK: begin
          ev_valid = 1'b1;
          ev_data  = data_byte_i;
          if (data_byte_i == jmsp_pkg::MK_SOI) begin
            state_d = jmsp_pkg::ST_FRAME;
          end else if (data_byte_i == jmsp_pkg::MK_EOI ||
                       data_byte_i == jmsp_pkg::BYTE_00) begin
            state_d = jmsp_pkg::ST_SEARCH;
          end else begin
            marker_d = data_byte_i;
            state_d  = jmsp_pkg::ST_LEN1;
          end
        end
        jmsp_pkg::ST_LEN1: begin
          len_d   = {data_byte_i, 8'h00};
          state_d = jmsp_pkg::ST_LEN2;
        end
        jmsp_pkg::ST_LEN2: begin
          pos_d = '0;
          row_d = '0;
          if (full_len <= jmsp_pkg::LEN_FIELD_BYTES) begin
            len_d   = '0;
            end_seg = 1'b1;
          end else begin
            len_d   = full_len - jmsp_pkg::LEN_FIELD_BYTES;
            state_d = jmsp_pkg::ST_BODY;
          end
        end
        jmsp_pkg::ST_BODY: begin
          if (marker_q == jmsp_pkg::MK_DQT) begin
            // Table-id byte opens each row; entries follow
            if (row_q == '0) begin
              tid_d = data_byte_i;
            end else if (tid_q[7:1] == 7'd0) begin
              ev_valid = 1'b1;
              ev_kind  = jmsp_pkg::EV_QUANT;
              ev_data  = data_byte_i;
              ev_qt    = tid_q[0];
              ev_qi    = row_idx[5:0];
            end
          end else if (marker_q == jmsp_pkg::MK_SOF0) begin
            case (pos_q)
              jmsp_pkg::SOF_HEIGHT_HI: height_d = {data_byte_i, height_q[7:0]};
              jmsp_pkg::SOF_HEIGHT_LO: height_d = {height_q[15:8], data_byte_i};
              jmsp_pkg::SOF_WIDTH_HI:  width_d  = {data_byte_i, width_q[7:0]};
              jmsp_pkg::SOF_WIDTH_LO:  width_d  = {width_q[15:8], data_byte_i};
              jmsp_pkg::SOF_SAMPLING: begin
                if (data_byte_i == jmsp_pkg::SAMP_H2V2) begin
                  luma_d = jmsp_pkg::LUMA_H2V2;
                end else if (data_byte_i == jmsp_pkg::SAMP_H2V1) begin
                  luma_d = jmsp_pkg::LUMA_H2V1;
                end
              end
              default: ;
            endcase
          end
          pos_d = pos_inc;
          row_d = (row_q == jmsp_pkg::DQT_ROW_LAST) ? '0
                                                    : row_q + jmsp_pkg::DQT_CNT_W'(1);
          if (pos_inc >= len_q) begin
            end_seg = 1'b1;
          end
        end
        jmsp_pkg::ST_SCAN: begin
          if (data_byte_i == jmsp_pkg::BYTE_FF) begin
            state_d = jmsp_pkg::ST_SCAN_FF;
          end else begin
            ev_valid = 1'b1;
            ev_kind  = jmsp_pkg::EV_SCAN_BYTE;
            ev_data  = data_byte_i;
          end
        end
        jmsp_pkg::ST_SCAN_FF: begin
          ev_valid = 1'b1;
          if (data_byte_i == jmsp_pkg::BYTE_00) begin
            // Drop the stuffed zero and pass the 0xFF on
            ev_kind = jmsp_pkg::EV_SCAN_BYTE;
            ev_data = jmsp_pkg::BYTE_FF;
            state_d = jmsp_pkg::ST_SCAN;
          end else if (data_byte_i inside {[jmsp_pkg::MK_RST0:jmsp_pkg::MK_RST7]}) begin
            ev_kind = jmsp_pkg::EV_RESTART;
            ev_data = data_byte_i;
            state_d = jmsp_pkg::ST_SCAN;
          end else begin
            ev_data = data_byte_i;
            state_d = jmsp_pkg::ST_SEARCH;
          end
        end
        default: begin
          state_d = (data_byte_i == jmsp_pkg::BYTE_FF) ? jmsp_pkg::ST_SOI
                                                        : jmsp_pkg::ST_SEARCH;
        end
      endcase

      // Close the segment: SOS opens the scan, others return between segments
      if (end_seg) begin
        if (marker_q == jmsp_pkg::MK_SOS) begin
          state_d  = jmsp_pkg::ST_SCAN;
          ev_valid = 1'b1;
          ev_kind  = jmsp_pkg::EV_SCAN_START;
          ev_data  = '0;
        end else begin
          state_d = jmsp_pkg::ST_FRAME;
        end
      end
    end
  end

  // Pack the event with the frame fields as updated by this byte
  always_comb begin
    event_o.kind        = ev_kind;
    event_o.data        = ev_data;
    event_o.quant_table = ev_qt;
    event_o.quant_index = ev_qi;
    event_o.height      = height_d;
    event_o.width       = width_d;
    event_o.luma        = luma_d;
  end

  assign event_valid_o = ev_valid;

endmodule

`default_nettype wire

/* rtl/jmsp_queue.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment parser event queue
// Short register FIFO between the parser front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire jmsp_pkg::event_t  push_data_i,
  input  wire logic              pop_i,
  output jmsp_pkg::event_t       head_o,
  output logic                   empty_o,
  output logic                   full_o
);

  jmsp_pkg::event_t entry_q [jmsp_pkg::QUEUE_DEPTH];
  logic [jmsp_pkg::QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [jmsp_pkg::QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [jmsp_pkg::QUEUE_AW:0]   count_q, count_d;

  // Store pushed events
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + jmsp_pkg::QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + jmsp_pkg::QUEUE_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (jmsp_pkg::QUEUE_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (jmsp_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (jmsp_pkg::QUEUE_AW+1)'(jmsp_pkg::QUEUE_DEPTH));

  // Occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (jmsp_pkg::QUEUE_AW+1)'(jmsp_pkg::QUEUE_DEPTH))
    else $error("event queue overfilled");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("event queue popped while empty");

  // No push into a full queue unless a pop frees a slot
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("event queue pushed while full");

  // Pointers stay consistent with occupancy
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("event queue pointers disagree with count");

endmodule

`default_nettype wire

/* rtl/jmsp_back.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment parser output stage
// Pulls events from the queue into an output register and expands the
// compact record into the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jmsp_pkg::event_t  head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             event_kind_o,
  output logic [7:0]             marker_code_o,
  output logic [7:0]             scan_byte_o,
  output logic                   quant_table_o,
  output logic [5:0]             quant_index_o,
  output logic [7:0]             quant_value_o,
  output logic [15:0]            image_height_o,
  output logic [15:0]            image_width_o,
  output logic [2:0]             luma_blocks_o
);

  logic             valid_q, valid_d;
  jmsp_pkg::event_t ev_q;
  logic             is_marker;

  // Load when the register is free or being emptied
  assign pop_o   = !empty_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q <= head_i;
    end
  end

  // Route the data byte to the field its kind names
  assign is_marker = (ev_q.kind == jmsp_pkg::EV_MARKER) ||
                     (ev_q.kind == jmsp_pkg::EV_RESTART);

  assign out_valid_o    = valid_q;
  assign event_kind_o   = ev_q.kind;
  assign marker_code_o  = is_marker ? ev_q.data : 8'h00;
  assign scan_byte_o    = (ev_q.kind == jmsp_pkg::EV_SCAN_BYTE) ? ev_q.data : 8'h00;
  assign quant_value_o  = (ev_q.kind == jmsp_pkg::EV_QUANT) ? ev_q.data : 8'h00;
  assign quant_table_o  = ev_q.quant_table;
  assign quant_index_o  = ev_q.quant_index;
  assign image_height_o = ev_q.height;
  assign image_width_o  = ev_q.width;
  assign luma_blocks_o  = ev_q.luma;

endmodule

`default_nettype wire

/* rtl/jpeg_marker_segment_parser.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment parser
// Byte-stream parser for baseline JPEG: SOI search, segment walk, DQT entry
// writes, SOF0 frame fields, scan byte unstuffing and restart markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / data_byte_i) takes one file byte
//   per transaction. Output channel (out_valid_o / out_ready_i and the result
//   fields) gives at most one event per byte, in byte order.
//   Throughput: one byte per cycle, sustained, while the receiver keeps up.
//   An event caused by an accepted byte is written into the event queue and
//   is then loaded into the output register that drives the outputs.
//   The parser front end writes events into a four-entry queue; the output
//   register drains it. When the receiver stalls, the queue fills and
//   in_ready_o drops only once all four entries hold events; bytes that
//   cause no event still need a free entry to be taken.
//   Reset clears the parser to the SOI search, frame fields to zero, luma
//   blocks to two, and empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_marker_segment_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [7:0]       marker_code_o,
  output logic [7:0]       scan_byte_o,
  output logic             quant_table_o,
  output logic [5:0]       quant_index_o,
  output logic [7:0]       quant_value_o,
  output logic [15:0]      image_height_o,
  output logic [15:0]      image_width_o,
  output logic [2:0]       luma_blocks_o
);

  logic             accept;
  logic             ev_valid;
  jmsp_pkg::event_t ev;
  jmsp_pkg::event_t head;
  logic             q_empty;
  logic             q_full;
  logic             q_pop;

  // Take a byte whenever the queue has room for its event
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  jmsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .event_o       (ev),
    .event_valid_o (ev_valid)
  );

  jmsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ev_valid),
    .push_data_i (ev),
    .pop_i       (q_pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  jmsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (q_empty),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .marker_code_o  (marker_code_o),
    .scan_byte_o    (scan_byte_o),
    .quant_table_o  (quant_table_o),
    .quant_index_o  (quant_index_o),
    .quant_value_o  (quant_value_o),
    .image_height_o (image_height_o),
    .image_width_o  (image_width_o),
    .luma_blocks_o  (luma_blocks_o)
  );

endmodule

`default_nettype wire
